// ===== rtl/smpq_pkg.sv =====
// shared types and codes for the stable min-priority queue
package smpq_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_POP     = 2'd1,
    CMD_UPGRADE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_MORE_URGENT = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_SCAN,
    S_MATCH,
    S_UPDATE,
    S_RESP
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic do_exec;
    logic run_shift;
    logic start_scan;
    logic run_scan;
    logic run_match;
    logic do_update;
    logic load_out;
  } dp_ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic full;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/smpq_ctrl.sv =====
// sequencing state machine of the priority queue
module smpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  smpq_pkg::dp_stat_t stat,
  output smpq_pkg::dp_ctrl_t ctrl
);
  import smpq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (stat.cmd)
          CMD_POP:     state_nxt = stat.empty ? S_RESP : S_SHIFT;
          CMD_UPGRADE: state_nxt = stat.empty ? S_RESP : S_MATCH;
          default:     state_nxt = S_RESP;
        endcase
      end
      S_SHIFT: begin
        if (stat.walk_done) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.walk_done) state_nxt = S_RESP;
      end
      S_MATCH: begin
        if (stat.walk_done) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctrl     = '0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        ctrl.accept = in_valid;
      end
      S_EXEC: begin
        ctrl.do_exec = 1'b1;
      end
      S_SHIFT: begin
        ctrl.run_shift  = !stat.walk_done;
        ctrl.start_scan = stat.walk_done;
      end
      S_SCAN: begin
        ctrl.run_scan = 1'b1;
      end
      S_MATCH: begin
        ctrl.run_match = 1'b1;
      end
      S_UPDATE: begin
        ctrl.do_update = 1'b1;
      end
      S_RESP: begin
        ctrl.load_out = stat.out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

// ===== rtl/smpq_dp.sv =====
// entry store, front cache, walk pointer and result register
module smpq_dp #(
  parameter int DEPTH     = 64,
  parameter int ID_BITS   = 16,
  parameter int PRIO_BITS = 16,
  parameter int AW        = $clog2(DEPTH),
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smpq_pkg::cmd_t       in_command,
  input  logic [ID_BITS-1:0]   in_patient_id,
  input  logic [PRIO_BITS-1:0] in_priority_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smpq_pkg::status_t    out_status,
  output logic [ID_BITS-1:0]   out_popped_id,
  output logic                 out_front_valid,
  output logic [ID_BITS-1:0]   out_front_id,
  output logic [PRIO_BITS-1:0] out_front_priority,
  output logic [CW-1:0]        out_entry_count,
  input  smpq_pkg::dp_ctrl_t   ctrl,
  output smpq_pkg::dp_stat_t   stat
);
  import smpq_pkg::*;

  localparam int EW = ID_BITS + PRIO_BITS;

  // entry store, {id, priority} per slot
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  cmd_t                 cmd_r, cmd_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        rptr_r, rptr_nxt;
  logic                 rvld_r, rvld_nxt;
  logic [AW-1:0]        ridx_r, ridx_nxt;
  logic                 fv_r, fv_nxt;
  logic [AW-1:0]        fslot_r, fslot_nxt;
  logic [ID_BITS-1:0]   fid_r, fid_nxt;
  logic [PRIO_BITS-1:0] fprio_r, fprio_nxt;
  logic                 found_r, found_nxt;
  logic [AW-1:0]        sel_r, sel_nxt;
  logic [PRIO_BITS-1:0] sel_prio_r, sel_prio_nxt;
  status_t              status_r, status_nxt;
  logic [ID_BITS-1:0]   popped_r, popped_nxt;

  logic                 ov_r, ov_nxt;
  status_t              o_status_r, o_status_nxt;
  logic [ID_BITS-1:0]   o_popped_r, o_popped_nxt;
  logic                 o_fv_r, o_fv_nxt;
  logic [ID_BITS-1:0]   o_fid_r, o_fid_nxt;
  logic [PRIO_BITS-1:0] o_fprio_r, o_fprio_nxt;
  logic [CW-1:0]        o_count_r, o_count_nxt;

  logic [ID_BITS-1:0]   rd_id;
  logic [PRIO_BITS-1:0] rd_prio;
  logic                 walking;

  assign rd_id   = rdata_r[EW-1:PRIO_BITS];
  assign rd_prio = rdata_r[PRIO_BITS-1:0];
  assign walking = ctrl.run_shift | ctrl.run_scan | ctrl.run_match;

  assign stat.cmd       = cmd_r;
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.walk_done = (rptr_r >= count_r) && !rvld_r;
  assign stat.out_free  = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[rptr_r[AW-1:0]];
  end

  always_comb begin
    cmd_nxt      = cmd_r;
    id_nxt       = id_r;
    prio_nxt     = prio_r;
    count_nxt    = count_r;
    rptr_nxt     = rptr_r;
    fv_nxt       = fv_r;
    fslot_nxt    = fslot_r;
    fid_nxt      = fid_r;
    fprio_nxt    = fprio_r;
    found_nxt    = found_r;
    sel_nxt      = sel_r;
    sel_prio_nxt = sel_prio_r;
    status_nxt   = status_r;
    popped_nxt   = popped_r;
    ov_nxt       = ov_r;
    o_status_nxt = o_status_r;
    o_popped_nxt = o_popped_r;
    o_fv_nxt     = o_fv_r;
    o_fid_nxt    = o_fid_r;
    o_fprio_nxt  = o_fprio_r;
    o_count_nxt  = o_count_r;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '0;

    if (ctrl.accept) begin
      cmd_nxt    = in_command;
      id_nxt     = in_patient_id;
      prio_nxt   = in_priority_req;
      status_nxt = ST_OK;
      popped_nxt = '0;
    end

    if (ctrl.do_exec) begin
      case (cmd_r)
        CMD_INSERT: begin
          if (stat.full) begin
            status_nxt = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_wa    = count_r[AW-1:0];
            mem_wd    = {id_r, prio_r};
            count_nxt = count_r + CW'(1);
            if (!fv_r || prio_r < fprio_r) begin
              fv_nxt    = 1'b1;
              fslot_nxt = count_r[AW-1:0];
              fid_nxt   = id_r;
              fprio_nxt = prio_r;
            end
          end
        end
        CMD_POP: begin
          if (stat.empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            popped_nxt = fid_r;
            rptr_nxt   = CW'(fslot_r) + CW'(1);
          end
        end
        CMD_UPGRADE: begin
          if (stat.empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rptr_nxt  = '0;
            found_nxt = 1'b0;
          end
        end
        CMD_CLEAR: begin
          count_nxt = '0;
          fv_nxt    = 1'b0;
        end
        default: begin
          status_nxt = status_r;
        end
      endcase
    end

    // one read per cycle while walking the held entries
    mem_re   = walking && (rptr_r < count_r);
    rvld_nxt = mem_re;
    ridx_nxt = rptr_r[AW-1:0];
    if (mem_re) rptr_nxt = rptr_r + CW'(1);

    // close the gap: slot i+1 moves to slot i
    if (ctrl.run_shift && rvld_r) begin
      mem_we = 1'b1;
      mem_wa = ridx_r - AW'(1);
      mem_wd = rdata_r;
    end

    if (ctrl.start_scan) begin
      count_nxt = count_r - CW'(1);
      rptr_nxt  = '0;
      fv_nxt    = 1'b0;
    end

    // strict compare keeps the earliest slot on a tie
    if (ctrl.run_scan && rvld_r) begin
      if (!fv_r || rd_prio < fprio_r) begin
        fv_nxt    = 1'b1;
        fslot_nxt = ridx_r;
        fid_nxt   = rd_id;
        fprio_nxt = rd_prio;
      end
    end

    if (ctrl.run_match && rvld_r && rd_id == id_r) begin
      if (!found_r || rd_prio < sel_prio_r) begin
        found_nxt    = 1'b1;
        sel_nxt      = ridx_r;
        sel_prio_nxt = rd_prio;
      end
    end

    if (ctrl.do_update) begin
      if (!found_r) begin
        status_nxt = ST_NOT_FOUND;
      end else if (sel_prio_r < prio_r) begin
        status_nxt = ST_MORE_URGENT;
      end else begin
        mem_we = 1'b1;
        mem_wa = sel_r;
        mem_wd = {id_r, prio_r};
        if (prio_r < fprio_r || (prio_r == fprio_r && sel_r <= fslot_r)) begin
          fslot_nxt = sel_r;
          fid_nxt   = id_r;
          fprio_nxt = prio_r;
        end
      end
    end

    if (ctrl.load_out) begin
      ov_nxt       = 1'b1;
      o_status_nxt = status_r;
      o_popped_nxt = popped_r;
      o_fv_nxt     = fv_r;
      o_fid_nxt    = fv_r ? fid_r : '0;
      o_fprio_nxt  = fv_r ? fprio_r : '0;
      o_count_nxt  = count_r;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rptr_r  <= '0;
      rvld_r  <= 1'b0;
      fv_r    <= 1'b0;
      found_r <= 1'b0;
      ov_r    <= 1'b0;
      cmd_r   <= CMD_INSERT;
    end else begin
      count_r <= count_nxt;
      rptr_r  <= rptr_nxt;
      rvld_r  <= rvld_nxt;
      fv_r    <= fv_nxt;
      found_r <= found_nxt;
      ov_r    <= ov_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    prio_r     <= prio_nxt;
    ridx_r     <= ridx_nxt;
    fslot_r    <= fslot_nxt;
    fid_r      <= fid_nxt;
    fprio_r    <= fprio_nxt;
    sel_r      <= sel_nxt;
    sel_prio_r <= sel_prio_nxt;
    status_r   <= status_nxt;
    popped_r   <= popped_nxt;
    o_status_r <= o_status_nxt;
    o_popped_r <= o_popped_nxt;
    o_fv_r     <= o_fv_nxt;
    o_fid_r    <= o_fid_nxt;
    o_fprio_r  <= o_fprio_nxt;
    o_count_r  <= o_count_nxt;
  end

  assign out_valid          = ov_r;
  assign out_status         = o_status_r;
  assign out_popped_id      = o_popped_r;
  assign out_front_valid    = o_fv_r;
  assign out_front_id       = o_fid_r;
  assign out_front_priority = o_fprio_r;
  assign out_entry_count    = o_count_r;

endmodule

// ===== rtl/stable_min_priority_queue.sv =====
// top level of the stable min-priority queue
//
// min-priority queue of (id, priority) entries kept in arrival order in a
// single-port-read entry store of DEPTH slots. the front is the entry with
// the smallest priority value, earliest arrival on a tie, and is cached in
// registers so insert and clear need no walk of the store. upgrade walks
// all N held entries once to find the most urgent entry with the id. pop
// closes the gap by moving each later entry down one slot and then walks
// the remaining entries to find the new front. both walks are paced by
// the store's one registered read per cycle. one request is worked on at
// a time; its result lands in an output register, so a new request is
// taken while the previous result still waits for out_ready. the store
// needs no clearing after reset since only slots below the count are ever
// read.
module stable_min_priority_queue #(
  parameter int DEPTH     = 64,
  parameter int ID_BITS   = 16,
  parameter int PRIO_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  smpq_pkg::cmd_t                 in_command,
  input  logic [ID_BITS-1:0]             in_patient_id,
  input  logic [PRIO_BITS-1:0]           in_priority_req,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output smpq_pkg::status_t              out_status,
  output logic [ID_BITS-1:0]             out_popped_id,
  output logic                           out_front_valid,
  output logic [ID_BITS-1:0]             out_front_id,
  output logic [PRIO_BITS-1:0]           out_front_priority,
  output logic [$clog2(DEPTH + 1)-1:0]   out_entry_count
);
  import smpq_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // sequencer: accept, execute, walk the store, respond
  smpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // store, front cache and result register
  smpq_dp #(
    .DEPTH     (DEPTH),
    .ID_BITS   (ID_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_patient_id      (in_patient_id),
    .in_priority_req    (in_priority_req),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_popped_id      (out_popped_id),
    .out_front_valid    (out_front_valid),
    .out_front_id       (out_front_id),
    .out_front_priority (out_front_priority),
    .out_entry_count    (out_entry_count),
    .ctrl               (ctrl),
    .stat               (stat)
  );

endmodule
